// ===== src/pslm_pkg.sv =====
// Shared types and constants of the packet sequence loss monitor.
package pslm_pkg;

  localparam logic [31:0] PROBE_MAGIC   = 32'h5a54_5550;
  localparam logic [15:0] PROBE_VERSION = 16'd1;
  localparam logic [15:0] HEADER_BYTES  = 16'd40;

  localparam int SEQ_WINDOW_DEF = 65536;
  localparam int WORD_BITS      = 64;

  localparam int DIV_W      = 64;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int REM_W      = 20;
  localparam int MS_W       = 45;
  localparam logic [REM_W:0] NS_PER_MS = (REM_W + 1)'(1000000);

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_INVALID   = 3'd2,
    ST_END_MARK  = 3'd3,
    ST_BEYOND    = 3'd4
  } pslm_status_t;

  typedef struct packed {
    logic        bad_hdr;
    logic        is_end;
    logic        seq_nz;
    logic        beyond;
    logic [15:0] len;
    logic [63:0] stream;
    logic [63:0] seq;
    logic [63:0] seq_m1;
    logic [63:0] arrival;
  } pslm_item_t;

  typedef struct packed {
    pslm_item_t            item;
    logic [MS_W-1:0]       ms;
  } pslm_fitem_t;

endpackage

// ===== src/pslm_in_if.sv =====
// Input channel of the monitor: one received datagram header per item.
interface pslm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] datagram_length;
  logic [31:0] magic_word;
  logic [15:0] format_version;
  logic [15:0] header_flags;
  logic [63:0] stream_ident;
  logic [63:0] sequence_number;
  logic [63:0] arrival_time_ns;

  modport source (
    output valid, datagram_length, magic_word, format_version, header_flags,
           stream_ident, sequence_number, arrival_time_ns,
    input  ready
  );
  modport sink (
    input  valid, datagram_length, magic_word, format_version, header_flags,
           stream_ident, sequence_number, arrival_time_ns,
    output ready
  );
endinterface

// ===== src/pslm_out_if.sv =====
// Result channel of the monitor: status and running totals per item.
interface pslm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_status;
  logic [31:0] received_count;
  logic [47:0] byte_total;
  logic [63:0] lost_count;
  logic [31:0] reorder_count;
  logic [31:0] duplicate_count;
  logic [31:0] invalid_count;
  logic [63:0] highest_sequence;
  logic [63:0] largest_gap_ns;
  logic [31:0] peak_per_ms;
  logic        end_seen;

  modport source (
    output valid, item_status, received_count, byte_total, lost_count, reorder_count,
           duplicate_count, invalid_count, highest_sequence, largest_gap_ns,
           peak_per_ms, end_seen,
    input  ready
  );
  modport sink (
    input  valid, item_status, received_count, byte_total, lost_count, reorder_count,
           duplicate_count, invalid_count, highest_sequence, largest_gap_ns,
           peak_per_ms, end_seen,
    output ready
  );
endinterface

// ===== src/packet_sequence_loss_monitor.sv =====
// Top level of the packet sequence loss monitor.
//
// in_chan carries one received probe datagram header per item: length, magic,
// version, flags, stream id, sequence number and arrival time in ns.
// out_chan returns one item per input item: a status code and the running
// totals (received, bytes, lost, reorders, duplicates, invalid, highest
// sequence, largest arrival gap, per-millisecond peak, end marker seen).
// Both channels use valid/ready; an item moves when both are high.
// An item first passes a pipeline that divides the arrival time by 10^6
// one byte per stage, then a read-modify-write of the seen-bitmap word:
// a registered bitmap read, then the commit. The read-modify-write stage holds
// one item from its bitmap read until its commit, so it takes no new item
// before the last one is committed.
// Totals are held in registers that stay stable while a result waits, so a
// stalled receiver holds the result and the pipeline fills up behind it.
// After reset the bitmap is cleared one 64-bit word per cycle, in all
// ceil(SEQ_WINDOW / 64) words (1024 by default); in_chan.ready stays low
// until the clear is done.
module packet_sequence_loss_monitor import pslm_pkg::*; #(
  parameter int SEQ_WINDOW = SEQ_WINDOW_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pslm_in_if.sink    in_chan,
  pslm_out_if.source out_chan
);

  logic        f_valid;
  logic        f_take;
  logic        clr_busy;
  pslm_fitem_t f_item;

  pslm_front #(
    .SEQ_WINDOW (SEQ_WINDOW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold    (clr_busy),
    .take    (f_take),
    .f_valid (f_valid),
    .f_item  (f_item),
    .in_ch   (in_chan)
  );

  pslm_core #(
    .SEQ_WINDOW (SEQ_WINDOW)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .f_valid  (f_valid),
    .f_item   (f_item),
    .f_take   (f_take),
    .clr_busy (clr_busy),
    .out_ch   (out_chan)
  );

endmodule

// ===== src/pslm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pslm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pslm_front.sv =====
// Input decode and pipelined division of the arrival time into milliseconds.
module pslm_front import pslm_pkg::*; #(
  parameter int SEQ_WINDOW = SEQ_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hold,
  input  logic        take,
  output logic        f_valid,
  output pslm_fitem_t f_item,
  pslm_in_if.sink     in_ch
);

  typedef struct packed {
    pslm_item_t       item;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] quo;
  } stage_t;

  stage_t                  st_r   [DIV_STAGES];
  stage_t                  st_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0]   vld_r;
  logic                    adv;
  logic                    in_take;
  pslm_item_t              in_item;

  function automatic logic [REM_W+DIV_BITS-1:0] div_digit(
    input logic [REM_W-1:0]    rem_in,
    input logic [DIV_BITS-1:0] dig
  );
    logic [REM_W:0]    r;
    logic [DIV_BITS-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      r = {r[REM_W-1:0], dig[i]};
      if (r >= NS_PER_MS) begin
        r    = r - NS_PER_MS;
        q[i] = 1'b1;
      end
    end
    return {r[REM_W-1:0], q};
  endfunction

  assign adv         = !vld_r[DIV_STAGES-1] || take;
  assign in_ch.ready = adv && !hold;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_item.bad_hdr = (in_ch.datagram_length < HEADER_BYTES) ||
                      (in_ch.magic_word != PROBE_MAGIC) ||
                      (in_ch.format_version != PROBE_VERSION);
    in_item.is_end  = in_ch.header_flags[0];
    in_item.seq_nz  = (in_ch.sequence_number != 64'd0);
    in_item.beyond  = (in_ch.sequence_number >= 64'(SEQ_WINDOW));
    in_item.len     = in_ch.datagram_length;
    in_item.stream  = in_ch.stream_ident;
    in_item.seq     = in_ch.sequence_number;
    in_item.seq_m1  = in_ch.sequence_number - 64'd1;
    in_item.arrival = in_ch.arrival_time_ns;
  end

  always_comb begin
    logic [REM_W+DIV_BITS-1:0] dres;
    dres             = div_digit('0, in_item.arrival[DIV_W-1 -: DIV_BITS]);
    st_nxt[0].item   = in_item;
    st_nxt[0].rem    = dres[REM_W+DIV_BITS-1:DIV_BITS];
    st_nxt[0].quo    = DIV_W'(dres[DIV_BITS-1:0]);
    for (int k = 1; k < DIV_STAGES; k++) begin
      dres = div_digit(st_r[k-1].rem,
                       st_r[k-1].item.arrival[DIV_W-1-k*DIV_BITS -: DIV_BITS]);
      st_nxt[k].item = st_r[k-1].item;
      st_nxt[k].rem  = dres[REM_W+DIV_BITS-1:DIV_BITS];
      st_nxt[k].quo  = {st_r[k-1].quo[DIV_W-DIV_BITS-1:0], dres[DIV_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r[0] <= in_take;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign f_valid     = vld_r[DIV_STAGES-1];
  assign f_item.item = st_r[DIV_STAGES-1].item;
  assign f_item.ms   = st_r[DIV_STAGES-1].quo[MS_W-1:0];

endmodule

// ===== src/pslm_core.sv =====
// Seen-bitmap read-modify-write, running totals and result register.
module pslm_core import pslm_pkg::*; #(
  parameter int SEQ_WINDOW = SEQ_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        f_valid,
  input  pslm_fitem_t f_item,
  output logic        f_take,
  output logic        clr_busy,
  pslm_out_if.source  out_ch
);

  localparam int MAP_WORDS = (SEQ_WINDOW + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  logic                 clr_active_r;
  logic [AW-1:0]        clr_addr_r;

  logic                 b_valid_r;
  pslm_fitem_t          b_item_r;
  logic [63:0]          gap_r;
  logic                 last_nz_r;
  logic                 stream_ne_r;
  logic                 m1_gt_r;
  logic                 seq_gt_r;
  logic                 seq_lt_r;
  logic                 ms_ne_r;

  logic                 out_valid_r;
  pslm_status_t         status_r,   status_nxt;
  logic [63:0]          latched_r,  latched_nxt;
  logic                 have_r,     have_nxt;
  logic [63:0]          highest_r,  highest_nxt;
  logic [31:0]          received_r, received_nxt;
  logic [47:0]          bytes_r,    bytes_nxt;
  logic [31:0]          dup_r,      dup_nxt;
  logic [31:0]          reord_r,    reord_nxt;
  logic [31:0]          inval_r,    inval_nxt;
  logic [63:0]          last_arr_r, last_arr_nxt;
  logic [63:0]          max_gap_r,  max_gap_nxt;
  logic [MS_W-1:0]      cur_ms_r,   cur_ms_nxt;
  logic [31:0]          pkt_ms_r,   pkt_ms_nxt;
  logic [31:0]          max_pkt_r,  max_pkt_nxt;
  logic                 end_r,      end_nxt;

  logic                 commit;
  logic                 wr_commit;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] bit_mask;
  logic [48:0]          byte_sum;
  logic [63:0]          expected;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;

  assign clr_busy = clr_active_r;
  assign f_take   = f_valid && !b_valid_r && !clr_active_r;
  assign commit   = b_valid_r && (!out_valid_r || out_ch.ready);
  assign bit_mask = WORD_BITS'(1) << b_item_r.item.seq[BW-1:0];
  assign byte_sum = {1'b0, bytes_r} + 49'(b_item_r.item.len);

  assign ram_wr_en   = clr_active_r || wr_commit;
  assign ram_wr_addr = clr_active_r ? clr_addr_r : b_item_r.item.seq[BW +: AW];
  assign ram_wr_data = clr_active_r ? '0 : (rd_data | bit_mask);

  pslm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (f_take),
    .rd_addr (f_item.item.seq[BW +: AW]),
    .rd_data (rd_data)
  );

  always_comb begin
    status_nxt   = status_r;
    latched_nxt  = latched_r;
    have_nxt     = have_r;
    highest_nxt  = highest_r;
    received_nxt = received_r;
    bytes_nxt    = bytes_r;
    dup_nxt      = dup_r;
    reord_nxt    = reord_r;
    inval_nxt    = inval_r;
    last_arr_nxt = last_arr_r;
    max_gap_nxt  = max_gap_r;
    cur_ms_nxt   = cur_ms_r;
    pkt_ms_nxt   = pkt_ms_r;
    max_pkt_nxt  = max_pkt_r;
    end_nxt      = end_r;
    wr_commit    = 1'b0;
    if (commit) begin
      if (b_item_r.item.bad_hdr || ((latched_r != 64'd0) && stream_ne_r)) begin
        inval_nxt  = inc32(inval_r);
        status_nxt = ST_INVALID;
      end else begin
        if (latched_r == 64'd0) begin
          latched_nxt = b_item_r.item.stream;
        end
        if (b_item_r.item.is_end) begin
          if (b_item_r.item.seq_nz) begin
            if (!have_r || m1_gt_r) begin
              highest_nxt = b_item_r.item.seq_m1;
            end
            have_nxt = 1'b1;
          end
          end_nxt    = 1'b1;
          status_nxt = ST_END_MARK;
        end else if (b_item_r.item.beyond) begin
          inval_nxt  = inc32(inval_r);
          status_nxt = ST_BEYOND;
        end else begin
          if (!have_r) begin
            highest_nxt = b_item_r.item.seq;
            have_nxt    = 1'b1;
          end else begin
            if (seq_lt_r) begin
              reord_nxt = inc32(reord_r);
            end
            if (seq_gt_r) begin
              highest_nxt = b_item_r.item.seq;
            end
          end
          if ((rd_data & bit_mask) != '0) begin
            dup_nxt    = inc32(dup_r);
            status_nxt = ST_DUPLICATE;
          end else begin
            wr_commit    = 1'b1;
            status_nxt   = ST_ACCEPTED;
            received_nxt = inc32(received_r);
            bytes_nxt    = byte_sum[48] ? '1 : byte_sum[47:0];
            if (last_nz_r && (gap_r > max_gap_r)) begin
              max_gap_nxt = gap_r;
            end
            last_arr_nxt = b_item_r.item.arrival;
            if (ms_ne_r) begin
              if (pkt_ms_r > max_pkt_r) begin
                max_pkt_nxt = pkt_ms_r;
              end
              cur_ms_nxt = b_item_r.ms;
              pkt_ms_nxt = 32'd1;
            end else begin
              pkt_ms_nxt = inc32(pkt_ms_r);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      b_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_ACCEPTED;
      latched_r    <= '0;
      have_r       <= 1'b0;
      highest_r    <= '0;
      received_r   <= '0;
      bytes_r      <= '0;
      dup_r        <= '0;
      reord_r      <= '0;
      inval_r      <= '0;
      last_arr_r   <= '0;
      max_gap_r    <= '0;
      cur_ms_r     <= '0;
      pkt_ms_r     <= '0;
      max_pkt_r    <= '0;
      end_r        <= 1'b0;
    end else begin
      if (clr_active_r) begin
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
      end
      if (f_take) begin
        b_valid_r <= 1'b1;
      end else if (commit) begin
        b_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      status_r   <= status_nxt;
      latched_r  <= latched_nxt;
      have_r     <= have_nxt;
      highest_r  <= highest_nxt;
      received_r <= received_nxt;
      bytes_r    <= bytes_nxt;
      dup_r      <= dup_nxt;
      reord_r    <= reord_nxt;
      inval_r    <= inval_nxt;
      last_arr_r <= last_arr_nxt;
      max_gap_r  <= max_gap_nxt;
      cur_ms_r   <= cur_ms_nxt;
      pkt_ms_r   <= pkt_ms_nxt;
      max_pkt_r  <= max_pkt_nxt;
      end_r      <= end_nxt;
    end
  end

  // Compare against the state left by the previous item, which is final by now.
  always_ff @(posedge clk) begin
    if (f_take) begin
      b_item_r    <= f_item;
      gap_r       <= f_item.item.arrival - last_arr_r;
      last_nz_r   <= (last_arr_r != 64'd0);
      stream_ne_r <= (f_item.item.stream != latched_r);
      m1_gt_r     <= (f_item.item.seq_m1 > highest_r);
      seq_gt_r    <= (f_item.item.seq > highest_r);
      seq_lt_r    <= (f_item.item.seq < highest_r);
      ms_ne_r     <= (f_item.ms != cur_ms_r);
    end
  end

  assign expected = highest_r + 64'd1;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.item_status      = status_r;
  assign out_ch.received_count   = received_r;
  assign out_ch.byte_total       = bytes_r;
  assign out_ch.lost_count       = (have_r && (expected > 64'(received_r))) ?
                                   expected - 64'(received_r) : 64'd0;
  assign out_ch.reorder_count    = reord_r;
  assign out_ch.duplicate_count  = dup_r;
  assign out_ch.invalid_count    = inval_r;
  assign out_ch.highest_sequence = highest_r;
  assign out_ch.largest_gap_ns   = max_gap_r;
  assign out_ch.peak_per_ms      = (max_pkt_r > pkt_ms_r) ? max_pkt_r : pkt_ms_r;
  assign out_ch.end_seen         = end_r;

endmodule

// ===== sim/pslm_loss_checker.sv =====
// Predictor and result checker for the packet sequence loss monitor.
module pslm_loss_checker import pslm_pkg::*; #(
  parameter int SEQ_WINDOW = SEQ_WINDOW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pslm_in_if   in_mon,
  pslm_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int          MAP_WORDS = (SEQ_WINDOW + WORD_BITS - 1) / WORD_BITS;
  localparam logic [63:0] MS_NS     = 64'd1000000;
  localparam int          END_BIT   = 0;

  typedef struct packed {
    logic [15:0] len;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] flags;
    logic [63:0] stream;
    logic [63:0] seq;
    logic [63:0] arrival;
  } datagram_t;

  typedef struct packed {
    pslm_status_t status;
    logic [31:0]  received;
    logic [47:0]  bytes;
    logic [63:0]  lost;
    logic [31:0]  reorders;
    logic [31:0]  duplicates;
    logic [31:0]  invalids;
    logic [63:0]  highest;
    logic [63:0]  gap;
    logic [31:0]  peak;
    logic         end_seen;
  } totals_t;

  logic [63:0] seen_words [MAP_WORDS];
  logic [63:0] stream_latch;
  logic        have_seq;
  logic [63:0] highest;
  logic [31:0] received;
  logic [47:0] bytes_sum;
  logic [31:0] duplicates;
  logic [31:0] reorders;
  logic [31:0] invalids;
  logic [63:0] last_arrival;
  logic [63:0] max_gap;
  logic [63:0] cur_ms;
  logic [31:0] pkts_ms;
  logic [31:0] peak_ms;
  logic        end_flag;
  totals_t     expected_totals [$];

  function automatic logic [31:0] bump32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic totals_t tally_datagram(datagram_t d);
    totals_t     t;
    logic [63:0] gap;
    logic [63:0] ms;
    logic [48:0] byte_next;
    int          word_ix;
    t = '0;
    t.status = ST_ACCEPTED;
    if (d.len < HEADER_BYTES || d.magic != PROBE_MAGIC || d.version != PROBE_VERSION ||
        (stream_latch != '0 && d.stream != stream_latch)) begin
      invalids = bump32(invalids);
      t.status = ST_INVALID;
    end else begin
      if (stream_latch == '0) stream_latch = d.stream;
      if (d.flags[END_BIT]) begin
        if (d.seq != '0) begin
          if (!have_seq || d.seq - 64'd1 > highest) highest = d.seq - 64'd1;
          have_seq = 1'b1;
        end
        end_flag = 1'b1;
        t.status = ST_END_MARK;
      end else if (d.seq >= 64'(SEQ_WINDOW)) begin
        invalids = bump32(invalids);
        t.status = ST_BEYOND;
      end else begin
        if (!have_seq) begin
          highest = d.seq;
          have_seq = 1'b1;
        end else begin
          if (d.seq < highest) reorders = bump32(reorders);
          if (d.seq > highest) highest = d.seq;
        end
        word_ix = int'(d.seq / WORD_BITS);
        if (word_ix >= MAP_WORDS) word_ix = MAP_WORDS - 1;
        if (seen_words[word_ix][d.seq[5:0]]) begin
          duplicates = bump32(duplicates);
          t.status = ST_DUPLICATE;
        end else begin
          seen_words[word_ix][d.seq[5:0]] = 1'b1;
          received = bump32(received);
          byte_next = {1'b0, bytes_sum} + 49'(d.len);
          bytes_sum = byte_next[48] ? '1 : byte_next[47:0];
          if (last_arrival != '0) begin
            gap = d.arrival - last_arrival;
            if (gap > max_gap) max_gap = gap;
          end
          last_arrival = d.arrival;
          ms = d.arrival / MS_NS;
          if (ms != cur_ms) begin
            if (pkts_ms > peak_ms) peak_ms = pkts_ms;
            cur_ms = ms;
            pkts_ms = 32'd1;
          end else begin
            pkts_ms = bump32(pkts_ms);
          end
        end
      end
    end
    t.received   = received;
    t.bytes      = bytes_sum;
    t.reorders   = reorders;
    t.duplicates = duplicates;
    t.invalids   = invalids;
    t.highest    = highest;
    t.gap        = max_gap;
    t.peak       = (peak_ms > pkts_ms) ? peak_ms : pkts_ms;
    t.end_seen   = end_flag;
    if (have_seq && highest + 64'd1 > 64'(received)) t.lost = highest + 64'd1 - 64'(received);
    else t.lost = '0;
    return t;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) $display("%m: %s expected %0h got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    totals_t   want;
    datagram_t d;
    if (!rst_n) begin
      for (int w = 0; w < MAP_WORDS; w++) seen_words[w] = '0;
      stream_latch = '0;
      have_seq     = 1'b0;
      highest      = '0;
      received     = '0;
      bytes_sum    = '0;
      duplicates   = '0;
      reorders     = '0;
      invalids     = '0;
      last_arrival = '0;
      max_gap      = '0;
      cur_ms       = '0;
      pkts_ms      = '0;
      peak_ms      = '0;
      end_flag     = 1'b0;
      fail_count   = 0;
      expected_totals.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_totals.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%m: unexpected result item, status %0d", out_mon.item_status);
        end else begin
          want = expected_totals.pop_front();
          check_field("item_status", 64'(want.status), 64'(out_mon.item_status));
          check_field("received_count", 64'(want.received), 64'(out_mon.received_count));
          check_field("byte_total", 64'(want.bytes), 64'(out_mon.byte_total));
          check_field("lost_count", want.lost, out_mon.lost_count);
          check_field("reorder_count", 64'(want.reorders), 64'(out_mon.reorder_count));
          check_field("duplicate_count", 64'(want.duplicates), 64'(out_mon.duplicate_count));
          check_field("invalid_count", 64'(want.invalids), 64'(out_mon.invalid_count));
          check_field("highest_sequence", want.highest, out_mon.highest_sequence);
          check_field("largest_gap_ns", want.gap, out_mon.largest_gap_ns);
          check_field("peak_per_ms", 64'(want.peak), 64'(out_mon.peak_per_ms));
          check_field("end_seen", 64'(want.end_seen), 64'(out_mon.end_seen));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        d.len     = in_mon.datagram_length;
        d.magic   = in_mon.magic_word;
        d.version = in_mon.format_version;
        d.flags   = in_mon.header_flags;
        d.stream  = in_mon.stream_ident;
        d.seq     = in_mon.sequence_number;
        d.arrival = in_mon.arrival_time_ns;
        expected_totals.push_back(tally_datagram(d));
      end
    end
    pending = expected_totals.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top of the packet sequence loss monitor: clock, reset, stimulus and verdict.
module tb;
  import pslm_pkg::*;

  localparam int          SEQ_WINDOW   = SEQ_WINDOW_DEF;
  localparam int          RANDOM_ITEMS = 1920;
  localparam int          CALM_TAIL    = 150;
  localparam int          IDLE_LIMIT   = 4000;
  localparam logic [15:0] END_MARK     = 16'h0001;

  typedef struct {
    logic [15:0] len;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] flags;
    logic [63:0] stream;
    logic [63:0] seq;
    logic [63:0] arrival;
  } datagram_t;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  int          ready_calm = 0;
  int          send_calm = 0;
  bit          quiet;
  logic [63:0] home_stream;
  logic [63:0] now_ns;
  logic [63:0] next_seq;

  pslm_in_if  in_chan();
  pslm_out_if out_chan();

  packet_sequence_loss_monitor #(.SEQ_WINDOW(SEQ_WINDOW)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pslm_loss_checker #(.SEQ_WINDOW(SEQ_WINDOW)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_chan.ready <= 1'b0;
    end else if (ready_calm > 0) begin
      ready_calm <= ready_calm - 1;
      out_chan.ready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 16);
      out_chan.ready <= 1'b0;
    end else begin
      ready_calm <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_datagram(datagram_t d);
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
      send_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
    end
    in_chan.valid           <= 1'b1;
    in_chan.datagram_length <= d.len;
    in_chan.magic_word      <= d.magic;
    in_chan.format_version  <= d.version;
    in_chan.header_flags    <= d.flags;
    in_chan.stream_ident    <= d.stream;
    in_chan.sequence_number <= d.seq;
    in_chan.arrival_time_ns <= d.arrival;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
  endtask

  function automatic logic [63:0] next_arrival();
    if ($urandom_range(0, 9) == 0) now_ns += 64'($urandom_range(1000000, 4000000));
    else now_ns += 64'($urandom_range(50, 200000));
    return now_ns;
  endfunction

  function automatic datagram_t probe(logic [63:0] seq, logic [15:0] flags,
                                      logic [63:0] arrival);
    datagram_t d;
    if ($urandom_range(0, 7) == 0) d.len = 16'($urandom_range(HEADER_BYTES, 65535));
    else d.len = 16'($urandom_range(HEADER_BYTES, 1500));
    d.magic   = PROBE_MAGIC;
    d.version = PROBE_VERSION;
    d.flags   = flags;
    d.stream  = home_stream;
    d.seq     = seq;
    d.arrival = arrival;
    return d;
  endfunction

  function automatic datagram_t noise();
    datagram_t d;
    d.len     = 16'($urandom);
    d.magic   = $urandom;
    d.version = 16'($urandom);
    d.flags   = 16'($urandom);
    d.stream  = {$urandom, $urandom};
    d.seq     = {$urandom, $urandom};
    d.arrival = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: d.len = 16'($urandom_range(0, HEADER_BYTES - 1));
      1: begin
        d.len = 16'($urandom_range(HEADER_BYTES, 65535));
        d.version = PROBE_VERSION;
        if (d.magic == PROBE_MAGIC) d.magic = ~d.magic;
      end
      2: begin
        d.len = 16'($urandom_range(HEADER_BYTES, 65535));
        d.magic = PROBE_MAGIC;
        if (d.version == PROBE_VERSION) d.version = '0;
      end
      default: begin
        d.len = 16'($urandom_range(HEADER_BYTES, 65535));
        d.magic = PROBE_MAGIC;
        d.version = PROBE_VERSION;
        if (d.stream == home_stream) d.stream = ~d.stream;
      end
    endcase
    return d;
  endfunction

  function automatic logic [63:0] next_probe_seq();
    int          pick;
    logic [63:0] seq;
    pick = $urandom_range(0, 99);
    if (pick < 10 && next_seq > 0) begin
      seq = next_seq - 64'($urandom_range(1, (next_seq < 24) ? int'(next_seq) : 24));
    end else begin
      if (pick < 20) next_seq += 64'($urandom_range(1, 4));
      seq = next_seq;
      next_seq += 64'd1;
    end
    return seq;
  endfunction

  initial begin
    datagram_t   d;
    int          pick;
    logic [63:0] seq;
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    quiet                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.datagram_length = '0;
    in_chan.magic_word      = '0;
    in_chan.format_version  = '0;
    in_chan.header_flags    = '0;
    in_chan.stream_ident    = '0;
    in_chan.sequence_number = '0;
    in_chan.arrival_time_ns = '0;
    home_stream             = {$urandom, $urandom} | 64'd1;
    now_ns                  = 64'd1000;
    next_seq                = 64'd8;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // zero stream while nothing is latched: taken, latch stays empty
    d = probe(64'd0, '0, next_arrival());
    d.stream = '0;
    send_datagram(d);
    d = probe(64'd1, '0, next_arrival());
    d.stream = ~home_stream;
    d.len = HEADER_BYTES - 16'd1;
    send_datagram(d);
    d = probe(64'd1, '0, next_arrival());
    d.magic = '0;
    d.len = '1;
    send_datagram(d);
    d = probe(64'd1, '0, next_arrival());
    d.magic = '1;
    send_datagram(d);
    d = probe(64'd1, '0, next_arrival());
    d.version = '0;
    send_datagram(d);
    d = probe(64'd1, '0, next_arrival());
    d.version = '1;
    d.len = '0;
    send_datagram(d);
    // first nonzero stream latches
    d = probe(64'd1, '0, next_arrival());
    d.len = HEADER_BYTES;
    send_datagram(d);
    d = probe(64'd2, '0, next_arrival());
    d.stream = '0;
    send_datagram(d);
    d = probe(64'd2, '0, next_arrival());
    d.stream = ~home_stream;
    send_datagram(d);
    d = probe(64'd1, 16'hFFFE, now_ns + 64'd10);
    d.len = '1;
    send_datagram(d);
    send_datagram(probe(64'd4, '0, now_ns + 64'd20));
    send_datagram(probe(64'd3, '0, now_ns + 64'd30));
    send_datagram(probe(64'd3, '0, now_ns + 64'd40));
    send_datagram(probe(64'd0, END_MARK, next_arrival()));
    d = probe(64'd9, 16'hFFFF, next_arrival());
    d.magic = ~PROBE_MAGIC;
    send_datagram(d);
    send_datagram(probe(64'd7, 16'hFFFF, next_arrival()));
    send_datagram(probe(64'd5, '0, next_arrival()));
    send_datagram(probe(64'(SEQ_WINDOW), '0, next_arrival()));
    send_datagram(probe('1, '0, next_arrival()));
    send_datagram(probe(64'd6, '0, now_ns + 64'd1000001));
    send_datagram(probe(64'd7, '0, now_ns + 64'd1000002));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= (n >= RANDOM_ITEMS - CALM_TAIL);
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        send_datagram(probe(next_probe_seq(), 16'($urandom) & ~END_MARK, next_arrival()));
      end else if (pick < 90) begin
        send_datagram(noise());
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0) seq = 64'(SEQ_WINDOW) + 64'($urandom_range(0, 3));
        else seq = {$urandom, $urandom} | 64'(SEQ_WINDOW);
        send_datagram(probe(seq, 16'($urandom) & ~END_MARK, next_arrival()));
      end else begin
        seq = (pick < 98) ? next_seq + 64'($urandom_range(0, 2)) : '0;
        send_datagram(probe(seq, 16'($urandom) | END_MARK, next_arrival()));
      end
    end

    // window edge, arrival oddities, then an end marker at the top of the sequence space
    send_datagram(probe(64'(SEQ_WINDOW - 1), '0, next_arrival()));
    send_datagram(probe(64'(SEQ_WINDOW - 1), '0, next_arrival()));
    send_datagram(probe(next_seq, '0, now_ns - 64'd5000));
    next_seq += 64'd1;
    send_datagram(probe(next_seq, '0, '0));
    next_seq += 64'd1;
    send_datagram(probe(next_seq, '0, next_arrival()));
    next_seq += 64'd1;
    send_datagram(probe(next_seq, '0, '1));
    next_seq += 64'd1;
    send_datagram(probe('1, END_MARK, next_arrival()));
    send_datagram(probe(next_seq, '0, next_arrival()));
    send_datagram(probe(64'd1, END_MARK, next_arrival()));

    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
